>>> rtl/hdd_pkg.sv
// Package with the shared constants and types of the histogram duplicate detector.
package hdd_pkg;
  localparam int unsigned BinsPerKey = 8;
  localparam int unsigned BinWidth   = 32;
  localparam int unsigned KeyWidth   = BinsPerKey * BinWidth;
  localparam int unsigned IdWidth    = 32;
  localparam int unsigned TotalWidth = 9;
  localparam logic [TotalWidth-1:0] TotalMax = '1;

  typedef logic [KeyWidth-1:0] key_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StRead   = 5'b00010,
    StComp   = 5'b00100,
    StFinish = 5'b01000,
    StOut    = 5'b10000
  } state_e;
endpackage

>>> rtl/hdd_if.sv
// Request and result channels of the histogram duplicate detector.
interface hdd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] histogram_id;
  logic [31:0] bin_0;
  logic [31:0] bin_1;
  logic [31:0] bin_2;
  logic [31:0] bin_3;
  logic [31:0] bin_4;
  logic [31:0] bin_5;
  logic [31:0] bin_6;
  logic [31:0] bin_7;
  logic        last_of_set;
  modport source (output valid, histogram_id, bin_0, bin_1, bin_2, bin_3, bin_4, bin_5,
                  bin_6, bin_7, last_of_set, input ready);
  modport sink (input valid, histogram_id, bin_0, bin_1, bin_2, bin_3, bin_4, bin_5,
                bin_6, bin_7, last_of_set, output ready);
endinterface

interface hdd_out_if;
  logic        valid;
  logic        ready;
  logic        is_duplicate;
  logic [31:0] echoed_id;
  logic [8:0]  duplicate_total;
  logic        table_full;
  logic        set_done;
  modport source (output valid, is_duplicate, echoed_id, duplicate_total, table_full,
                  set_done, input ready);
  modport sink (input valid, is_duplicate, echoed_id, duplicate_total, table_full,
                set_done, output ready);
endinterface

>>> rtl/hdd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hdd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/histogram_duplicate_detector.sv
// Top level of the histogram duplicate detector: sequencer, key store and result register.
// Each request is compared against the stored keys of the current set one slot at a time,
// using a single shared key comparator on the registered read port of the key RAM; each
// slot is read and then compared. The scan covers up to the number of keys stored so far
// in the set and stops at the first match; the result is then held until it is taken.
// Keys are kept in arrival order; the item flagged last of its set clears the table and
// the duplicate count once its result is formed.
module histogram_duplicate_detector
  import hdd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  hdd_in_if.sink    in_i,
  hdd_out_if.source out_o
);
  localparam int unsigned AddrWidth  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CountWidth = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CountWidth-1:0] CountFull = CountWidth'(TABLE_ENTRIES);

  state_e state_q, state_d;
  key_t key_q, rdata;
  logic [IdWidth-1:0] id_q;
  logic last_q, found_q, found_d;
  logic [CountWidth-1:0] used_q, used_d, scan_q, scan_d, scan_inc;
  logic [TotalWidth-1:0] dups_q, dups_d, dups_new;
  logic store_en, key_match;

  key_t in_key;
  assign in_key = {in_i.bin_7, in_i.bin_6, in_i.bin_5, in_i.bin_4,
                   in_i.bin_3, in_i.bin_2, in_i.bin_1, in_i.bin_0};

  assign in_i.ready = (state_q == StIdle);
  assign key_match  = (rdata == key_q);
  assign scan_inc   = scan_q + 1'b1;
  assign store_en   = (state_q == StFinish) && !found_q && (used_q != CountFull);
  assign dups_new   = (found_q && dups_q != TotalMax) ? dups_q + 1'b1 : dups_q;

  hdd_ram #(.Width(KeyWidth), .Depth(TABLE_ENTRIES)) u_keys (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (used_q[AddrWidth-1:0]),
    .wdata_i (key_q),
    .raddr_i (scan_q[AddrWidth-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    found_d = found_q;
    used_d  = used_q;
    dups_d  = dups_q;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          scan_d  = '0;
          found_d = 1'b0;
          state_d = (used_q == '0) ? StFinish : StRead;
        end
      end
      StRead: state_d = StComp;
      StComp: begin
        if (key_match) begin
          found_d = 1'b1;
          state_d = StFinish;
        end else begin
          scan_d  = scan_inc;
          state_d = (scan_inc == used_q) ? StFinish : StRead;
        end
      end
      StFinish: begin
        if (store_en) used_d = used_q + 1'b1;
        dups_d = dups_new;
        if (last_q) begin
          used_d = '0;
          dups_d = '0;
        end
        state_d = StOut;
      end
      StOut: begin
        if (out_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      found_q     <= 1'b0;
      used_q      <= '0;
      dups_q      <= '0;
      out_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      found_q <= found_d;
      used_q  <= used_d;
      dups_q  <= dups_d;
      if (state_q == StFinish) begin
        out_o.valid <= 1'b1;
      end else if (state_q == StOut && out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  // Payload registers: the request is captured on acceptance, the result when it is formed.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      key_q  <= in_key;
      id_q   <= in_i.histogram_id;
      last_q <= in_i.last_of_set;
    end
    if (state_q == StFinish) begin
      out_o.is_duplicate    <= found_q;
      out_o.echoed_id       <= id_q;
      out_o.duplicate_total <= dups_new;
      out_o.table_full      <= !found_q && (used_q == CountFull);
      out_o.set_done        <= last_q;
    end
  end
endmodule
